/* design/tsac_pkg.sv */
`timescale 1ns / 1ps

package tsac_pkg;

    // Field and datapath widths
    localparam int CONV_W  = 13;   // one ADC conversion
    localparam int SUM_W   = 17;   // sum of up to sixteen conversions
    localparam int CNT_W   = 5;    // sample counters and sample_count
    localparam int POS_W   = 9;    // screen coordinate
    localparam int DIFF_W  = CONV_W + 1;   // signed difference of two raw values
    localparam int SPAN_W  = POS_W + 1;    // signed output span
    localparam int PROD_W  = DIFF_W + SPAN_W;
    localparam int DIVD_W  = 22;   // dividend of the shared divider
    localparam int DIVS_W  = 13;   // divisor of the shared divider
    localparam int IDX_W   = 3;    // configuration register index
    localparam int CFG_W   = 13;   // configuration write data

    localparam int MAX_SAMPLES = 16;

    localparam logic [POS_W-1:0] SHORT_EDGE = 9'd239;
    localparam logic [POS_W-1:0] LONG_EDGE  = 9'd319;

    // Input item commands
    typedef enum logic [1:0] {
        CMD_X      = 2'd0,
        CMD_Y      = 2'd1,
        CMD_PEN_UP = 2'd2
    } t_cmd;

    // Screen orientations
    typedef enum logic [1:0] {
        ORIENT_PORTRAIT       = 2'd0,
        ORIENT_LANDSCAPE      = 2'd1,
        ORIENT_PORTRAIT_FLIP  = 2'd2,
        ORIENT_LANDSCAPE_FLIP = 2'd3
    } t_orient;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_ORIENTATION   = 3'd0,
        CFG_PANEL_VARIANT = 3'd1,
        CFG_SAMPLE_COUNT  = 3'd2,
        CFG_X_CAL_MIN     = 3'd3,
        CFG_X_CAL_MAX     = 3'd4,
        CFG_Y_CAL_MIN     = 3'd5,
        CFG_Y_CAL_MAX     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        orientation;
        logic              panel_variant;
        logic [CNT_W-1:0]  sample_count;
        logic [CONV_W-1:0] x_cal_min;
        logic [CONV_W-1:0] x_cal_max;
        logic [CONV_W-1:0] y_cal_min;
        logic [CONV_W-1:0] y_cal_max;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CONV_W-1:0] raw_x_avg;
        logic [CONV_W-1:0] raw_y_avg;
        logic              touched;
    } t_result;

endpackage

/* design/tsac_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module tsac_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tsac_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [tsac_pkg::DIVS_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [tsac_pkg::DIVD_W-1:0]   o_quot
);
    import tsac_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quot;
    logic [DIVS_W-1:0] r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DIVS_W:0]   trial;
    logic              fits;
    logic [DIVS_W:0]   diff;

    // One trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_quot[DIVD_W-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
                r_quot <= {r_quot[DIVD_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/tsac_core.sv */
`timescale 1ns / 1ps

// Sample accumulation and calibration sequencer around the shared divider
module tsac_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_reply_high,
    input  logic [7:0]                  i_reply_low,
    input  tsac_pkg::t_cfg              i_cfg,
    input  logic                        i_slot_free,
    output logic                        o_res_valid,
    output tsac_pkg::t_result           o_res
);
    import tsac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XDIV_GO,
        S_XDIV_WAIT,
        S_YDIV_GO,
        S_YDIV_WAIT,
        S_MUL,
        S_MDIV_GO,
        S_MDIV_WAIT,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [SUM_W-1:0]         r_x_sum, n_x_sum;
    logic [SUM_W-1:0]         r_y_sum, n_y_sum;
    logic [CNT_W-1:0]         r_x_seen, n_x_seen;
    logic [CNT_W-1:0]         r_y_seen, n_y_seen;
    logic [CONV_W-1:0]        r_rx, n_rx;
    logic [CONV_W-1:0]        r_ry, n_ry;
    logic [POS_W-1:0]         r_px, n_px;
    logic [POS_W-1:0]         r_py, n_py;
    logic                     r_phase, n_phase;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [DIFF_W-1:0] r_den, n_den;
    logic [POS_W-1:0]         r_c, n_c;
    logic [POS_W-1:0]         r_hi, n_hi;
    logic                     r_neg, n_neg;

    logic [CONV_W-1:0]        conv;
    logic [CNT_W-1:0]         eff_n;

    // Mapping operand selection
    logic [CONV_W-1:0]        sel_v, sel_a, sel_b;
    logic                     sel_rev;
    logic [POS_W-1:0]         sel_hi;
    logic signed [DIFF_W-1:0] sel_diff, sel_den;
    logic signed [SPAN_W-1:0] sel_span;

    logic [PROD_W-1:0]        prod_mag;
    logic [DIFF_W-1:0]        den_mag;
    logic [DIVD_W-1:0]        fin_q;
    logic [POS_W-1:0]         fin_val;

    logic                     div_start;
    logic [DIVD_W-1:0]        div_dividend;
    logic [DIVS_W-1:0]        div_divisor;
    logic                     div_done;
    logic [DIVD_W-1:0]        div_q;

    // Signed quotient plus offset, clamped to 0..hi
    function automatic logic [POS_W-1:0] map_finish(
        input logic [DIVD_W-1:0] q,
        input logic              neg,
        input logic [POS_W-1:0]  c,
        input logic [POS_W-1:0]  hi
    );
        logic signed [PROD_W-1:0] sq;
        logic signed [PROD_W:0]   val;
        sq  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        val = $signed({sq[PROD_W-1], sq}) + $signed({{(PROD_W+1-POS_W){1'b0}}, c});
        if (val[PROD_W])
            map_finish = '0;
        else if (val > $signed({{(PROD_W+1-POS_W){1'b0}}, hi}))
            map_finish = hi;
        else
            map_finish = val[POS_W-1:0];
    endfunction

    assign conv = {i_reply_high, i_reply_low[7:3]};

    // Count of 0 acts as 1, above the maximum as the maximum
    always_comb begin
        if (i_cfg.sample_count == '0)
            eff_n = CNT_W'(1);
        else if (i_cfg.sample_count > CNT_W'(MAX_SAMPLES))
            eff_n = CNT_W'(MAX_SAMPLES);
        else
            eff_n = i_cfg.sample_count;
    end

    // Operands of the current axis mapping; phase 0 gives pos_x, phase 1 pos_y
    always_comb begin
        sel_rev = 1'b0;
        case (t_orient'(i_cfg.orientation))
            ORIENT_PORTRAIT: begin
                sel_v  = r_phase ? r_ry : r_rx;
                sel_a  = r_phase ? i_cfg.y_cal_min : i_cfg.x_cal_min;
                sel_b  = r_phase ? i_cfg.y_cal_max : i_cfg.x_cal_max;
                sel_hi = r_phase ? LONG_EDGE : SHORT_EDGE;
            end
            ORIENT_PORTRAIT_FLIP: begin
                sel_v  = r_phase ? r_ry : r_rx;
                sel_a  = r_phase ? i_cfg.y_cal_max : i_cfg.x_cal_max;
                sel_b  = r_phase ? i_cfg.y_cal_min : i_cfg.x_cal_min;
                sel_hi = r_phase ? LONG_EDGE : SHORT_EDGE;
            end
            ORIENT_LANDSCAPE: begin
                sel_v   = r_phase ? r_rx : r_ry;
                sel_a   = r_phase ? i_cfg.x_cal_min : i_cfg.y_cal_max;
                sel_b   = r_phase ? i_cfg.x_cal_max : i_cfg.y_cal_min;
                sel_hi  = r_phase ? SHORT_EDGE : LONG_EDGE;
                sel_rev = i_cfg.panel_variant;
            end
            default: begin
                sel_v   = r_phase ? r_rx : r_ry;
                sel_a   = r_phase ? i_cfg.x_cal_max : i_cfg.y_cal_min;
                sel_b   = r_phase ? i_cfg.x_cal_min : i_cfg.y_cal_max;
                sel_hi  = r_phase ? SHORT_EDGE : LONG_EDGE;
                sel_rev = i_cfg.panel_variant;
            end
        endcase
        sel_diff = $signed({1'b0, sel_v}) - $signed({1'b0, sel_a});
        sel_den  = $signed({1'b0, sel_b}) - $signed({1'b0, sel_a});
        sel_span = sel_rev ? -$signed({1'b0, sel_hi}) : $signed({1'b0, sel_hi});
    end

    // Magnitudes for the divider, and the finishing step
    always_comb begin
        prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        den_mag  = r_den[DIFF_W-1] ? DIFF_W'(-r_den) : DIFF_W'(r_den);
        fin_q    = (r_state == S_MDIV_WAIT) ? div_q : '0;
        fin_val  = map_finish(fin_q, r_neg, r_c, r_hi);
    end

    // Divider operand routing
    always_comb begin
        div_start    = 1'b0;
        div_dividend = prod_mag[DIVD_W-1:0];
        div_divisor  = den_mag[DIVS_W-1:0];
        case (r_state)
            S_XDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(r_x_sum);
                div_divisor  = DIVS_W'(eff_n);
            end
            S_YDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(r_y_sum);
                div_divisor  = DIVS_W'(eff_n);
            end
            S_MDIV_GO: begin
                div_start = (r_den != '0);
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_x_sum  = r_x_sum;
        n_y_sum  = r_y_sum;
        n_x_seen = r_x_seen;
        n_y_seen = r_y_seen;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_px     = r_px;
        n_py     = r_py;
        n_phase  = r_phase;
        n_prod   = r_prod;
        n_den    = r_den;
        n_c      = r_c;
        n_hi     = r_hi;
        n_neg    = r_neg;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_cmd))
                        CMD_X: begin
                            if (r_x_seen < eff_n) begin
                                n_x_sum  = r_x_sum + SUM_W'(conv);
                                n_x_seen = r_x_seen + 1'b1;
                            end
                        end
                        CMD_Y: begin
                            n_y_sum  = r_y_sum + SUM_W'(conv);
                            n_y_seen = r_y_seen + 1'b1;
                            if (n_y_seen >= eff_n)
                                n_state = S_XDIV_GO;
                        end
                        CMD_PEN_UP: begin
                            n_rx    = '0;
                            n_ry    = '0;
                            n_px    = '0;
                            n_py    = '0;
                            n_state = S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_XDIV_GO:   n_state = S_XDIV_WAIT;
            S_XDIV_WAIT: begin
                if (div_done) begin
                    n_rx    = div_q[CONV_W-1:0];
                    n_state = S_YDIV_GO;
                end
            end
            S_YDIV_GO:   n_state = S_YDIV_WAIT;
            S_YDIV_WAIT: begin
                if (div_done) begin
                    n_ry    = (r_rx == '0) ? '0 : div_q[CONV_W-1:0];
                    n_phase = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = sel_diff * sel_span;
                n_den   = sel_den;
                n_c     = sel_rev ? sel_hi : '0;
                n_hi    = sel_hi;
                n_state = S_MDIV_GO;
            end
            S_MDIV_GO: begin
                n_neg = r_prod[PROD_W-1] ^ r_den[DIFF_W-1];
                if (r_den != '0) begin
                    n_state = S_MDIV_WAIT;
                end else begin
                    // equal calibration ends: the output start value
                    if (r_phase) n_py = fin_val;
                    else         n_px = fin_val;
                    n_phase = 1'b1;
                    n_state = r_phase ? S_EMIT : S_MUL;
                end
            end
            S_MDIV_WAIT: begin
                if (div_done) begin
                    if (r_phase) n_py = fin_val;
                    else         n_px = fin_val;
                    n_phase = 1'b1;
                    n_state = r_phase ? S_EMIT : S_MUL;
                end
            end
            S_EMIT: begin
                if (i_slot_free) begin
                    n_x_sum  = '0;
                    n_y_sum  = '0;
                    n_x_seen = '0;
                    n_y_seen = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_x_sum  <= '0;
            r_y_sum  <= '0;
            r_x_seen <= '0;
            r_y_seen <= '0;
            r_phase  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_x_sum  <= n_x_sum;
            r_y_sum  <= n_y_sum;
            r_x_seen <= n_x_seen;
            r_y_seen <= n_y_seen;
            r_phase  <= n_phase;
        end
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_px   <= n_px;
        r_py   <= n_py;
        r_prod <= n_prod;
        r_den  <= n_den;
        r_c    <= n_c;
        r_hi   <= n_hi;
        r_neg  <= n_neg;
    end

    tsac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_EMIT);
    assign o_res.pos_x       = r_px;
    assign o_res.pos_y       = r_py;
    assign o_res.raw_x_avg   = r_rx;
    assign o_res.raw_y_avg   = r_ry;
    assign o_res.touched     = (r_rx != '0) || (r_ry != '0);

endmodule

/* design/touch_sample_average_calibrate.sv */
`timescale 1ns / 1ps

// Resistive touch front end: each input item carries one ADC conversion,
// rebuilt from two SPI reply bytes, or a pen-up command. X and Y conversions
// are summed up to sample_count per axis; the Y conversion that completes
// the count produces one result item with the averaged raw values and the
// calibrated, clamped screen position for the configured orientation. A
// pen-up item clears the sums and produces an all-zero result. X, surplus
// and unused-command items leave the block ready for the next item; a
// pen-up item holds it until its result enters the output register. The
// completing Y item occupies the block while one shared restoring divider,
// one quotient bit per cycle, is used in turn for the X average, the Y
// average and each axis mapping with a nonzero calibration span; a
// multiply step comes before each mapping. The block takes no input item
// while that sequence runs. Results pass through an output register, so
// the next item is taken while a result waits downstream. Configuration
// registers are written through their own port and must only be changed
// while the block is idle.
module touch_sample_average_calibrate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [7:0]                    i_reply_high,
    input  logic [7:0]                    i_reply_low,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tsac_pkg::POS_W-1:0]    o_pos_x,
    output logic [tsac_pkg::POS_W-1:0]    o_pos_y,
    output logic [tsac_pkg::CONV_W-1:0]   o_raw_x_avg,
    output logic [tsac_pkg::CONV_W-1:0]   o_raw_y_avg,
    output logic                          o_touched,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tsac_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [tsac_pkg::CFG_W-1:0]    i_cfg_data
);
    import tsac_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    res_valid;
    logic    slot_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orientation   <= 2'd0;
            r_cfg.panel_variant <= 1'b0;
            r_cfg.sample_count  <= CNT_W'(4);
            r_cfg.x_cal_min     <= '0;
            r_cfg.x_cal_max     <= '1;
            r_cfg.y_cal_min     <= '0;
            r_cfg.y_cal_max     <= '1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIENTATION:   r_cfg.orientation   <= i_cfg_data[1:0];
                CFG_PANEL_VARIANT: r_cfg.panel_variant <= i_cfg_data[0];
                CFG_SAMPLE_COUNT:  r_cfg.sample_count  <= i_cfg_data[CNT_W-1:0];
                CFG_X_CAL_MIN:     r_cfg.x_cal_min     <= i_cfg_data[CONV_W-1:0];
                CFG_X_CAL_MAX:     r_cfg.x_cal_max     <= i_cfg_data[CONV_W-1:0];
                CFG_Y_CAL_MIN:     r_cfg.y_cal_min     <= i_cfg_data[CONV_W-1:0];
                CFG_Y_CAL_MAX:     r_cfg.y_cal_max     <= i_cfg_data[CONV_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    tsac_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_reply_high (i_reply_high),
        .i_reply_low  (i_reply_low),
        .i_cfg        (r_cfg),
        .i_slot_free  (slot_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register: free when empty or being taken this cycle
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
        if (slot_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out.pos_x;
    assign o_pos_y     = r_out.pos_y;
    assign o_raw_x_avg = r_out.raw_x_avg;
    assign o_raw_y_avg = r_out.raw_y_avg;
    assign o_touched   = r_out.touched;

endmodule
